[hw/rtl/tpba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpba_pkg
// Shared types, sizes and codes of the two-pool bitmap page allocator.
// ----------------------------------------------------------------------------
package tpba_pkg;

  localparam int POOL_PAGES = 1024;
  localparam int WORD_W     = (POOL_PAGES < 32) ? POOL_PAGES : 32;
  localparam int WORDS      = POOL_PAGES / WORD_W;
  localparam int WA_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int PIX_W      = $clog2(POOL_PAGES);
  localparam int SZ_W       = $clog2(POOL_PAGES + 1);
  localparam int CNT_W      = 11;
  localparam int PAGE_W     = 20;
  localparam int RUN_W      = 12;
  localparam int XW         = 22;
  localparam int RAM_AW     = WA_W + 1;
  localparam int RAM_DEPTH  = 1 << RAM_AW;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_ROOM     = 3'd1,
    ST_ZERO        = 3'd2,
    ST_NOT_IN_POOL = 3'd3,
    ST_BAD_RANGE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOD_RD,
    S_MOD_WR,
    S_RESP
  } state_t;

  localparam logic [1:0] CFG_KBASE = 2'd0;
  localparam logic [1:0] CFG_KCNT  = 2'd1;
  localparam logic [1:0] CFG_UBASE = 2'd2;
  localparam logic [1:0] CFG_UCNT  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;

  // Clamp a page count register to the size of the map.
  function automatic logic [SZ_W-1:0] pool_size(input logic [CNT_W-1:0] c);
    if (int'(c) > POOL_PAGES) begin
      return SZ_W'(POOL_PAGES);
    end
    return SZ_W'(c);
  endfunction

endpackage

[hw/rtl/tpba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tpba_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/two_pool_bitmap_page_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_pool_bitmap_page_allocator_unit
// First-fit page allocator over two used-page bitmaps, kernel and user.
// ----------------------------------------------------------------------------
// Both bitmaps live in one RAM of 32-bit words, one row per word and pool;
// a row never written reads as all free, so the block is usable straight out
// of reset with no clearing pass. One transaction is worked at a time.
// An allocate scans the pool one word per cycle (up to 32 words for a full
// 1024-page pool), then marks the run with a read in S_MOD_RD and a write
// in S_MOD_WR for each word it touches. A free checks the run and then
// clears it, passing through S_MOD_RD and S_MOD_WR for each touched word
// in each pass. Zero counts, oversize counts and pages outside both pools
// go straight to S_RESP. A finished result is held in the output register.
// ----------------------------------------------------------------------------
module two_pool_bitmap_page_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic                        in_user_pool,
  input  logic                        in_panic_on_fail,
  input  logic [tpba_pkg::CNT_W-1:0]  in_page_count,
  input  logic [tpba_pkg::PAGE_W-1:0] in_page_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [tpba_pkg::PAGE_W-1:0] out_first_page,
  output logic                        out_fatal,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [tpba_pkg::PAGE_W-1:0] cfg_wdata
);

  import tpba_pkg::*;

  state_t state_r, state_nxt;

  logic [PAGE_W-1:0] kbase_r, ubase_r;
  logic [CNT_W-1:0]  kcnt_r, ucnt_r;
  logic [SZ_W-1:0]   ksize, usize;

  logic              pool_r, pool_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PAGE_W-1:0] base_r, base_nxt;
  logic [SZ_W-1:0]   size_r, size_nxt;
  logic              panic_r, panic_nxt;
  logic [PIX_W-1:0]  start_r, start_nxt;
  logic [WA_W-1:0]   last_wa_r, last_wa_nxt;
  logic [WA_W-1:0]   rd_wa_r, rd_wa_nxt;
  logic [WA_W-1:0]   ev_wa_r, ev_wa_nxt;
  logic              ev_pend_r, ev_pend_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [WA_W-1:0]   mod_wa_r, mod_wa_nxt;
  logic              check_r, check_nxt;
  logic              set_r, set_nxt;
  status_t           status_r, status_nxt;
  logic [PAGE_W-1:0] first_r, first_nxt;
  logic              fatal_r, fatal_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [PAGE_W-1:0] out_first_r, out_first_nxt;
  logic              out_fatal_r, out_fatal_nxt;

  logic [RAM_DEPTH-1:0] vld_r;
  logic                 rd_vld_r;
  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata, wd;

  // scan datapath
  logic [WORD_W-1:0] used;
  logic [BIT_W:0]    lu [0:BIT_W][0:WORD_W-1];
  logic [RUN_W-1:0]  run_j;
  logic [RUN_W-1:0]  run_out;
  logic              hit;
  logic [BIT_W-1:0]  hit_j;
  logic [XW-1:0]     hit_start;
  logic [XW-1:0]     g;

  // modify datapath
  logic [XW-1:0]     end_g;
  logic [WA_W-1:0]   mod_last;
  logic [WORD_W-1:0] mask;
  logic [XW-1:0]     gm;

  // free decode
  logic              in_k, in_u;
  logic [PAGE_W-1:0] fbase;
  logic [SZ_W-1:0]   fsize;
  logic [PAGE_W-1:0] fidx;

  logic              in_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_first_page = out_first_r;
  assign out_fatal      = out_fatal_r;

  assign ksize = pool_size(kcnt_r);
  assign usize = pool_size(ucnt_r);

  tpba_ram #(
    .W     (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = (state_r == S_SCAN) ? {pool_r, rd_wa_r} : {pool_r, mod_wa_r};
  assign ram_waddr = {pool_r, mod_wa_r};
  assign wd        = rd_vld_r ? ram_rdata : '0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r <= '0;
      kcnt_r  <= '0;
      ubase_r <= '0;
      ucnt_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KBASE: kbase_r <= cfg_wdata;
        CFG_KCNT:  kcnt_r  <= cfg_wdata[CNT_W-1:0];
        CFG_UBASE: ubase_r <= cfg_wdata;
        CFG_UCNT:  ucnt_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Free decode: the kernel pool wins where the ranges overlap
  always_comb begin
    in_k = (in_page_number >= kbase_r) &&
           ({1'b0, in_page_number} < ({1'b0, kbase_r} + (PAGE_W+1)'(ksize)));
    in_u = (in_page_number >= ubase_r) &&
           ({1'b0, in_page_number} < ({1'b0, ubase_r} + (PAGE_W+1)'(usize)));
    fbase = in_k ? kbase_r : ubase_r;
    fsize = in_k ? ksize : usize;
    fidx  = in_page_number - fbase;
  end

  // Word scan: prefix of the last used bit, then run length at each bit
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      g       = (XW'(ev_wa_r) << BIT_W) + XW'(j);
      used[j] = wd[j] || (g >= XW'(size_r));
      lu[0][j] = used[j] ? (BIT_W+1)'(j + 1) : '0;
    end
    for (int lv = 0; lv < BIT_W; lv++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (j >= (1 << lv) && lu[lv][j] == '0) begin
          lu[lv+1][j] = lu[lv][j - (1 << lv)];
        end else begin
          lu[lv+1][j] = lu[lv][j];
        end
      end
    end
    hit   = 1'b0;
    hit_j = '0;
    run_j = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (lu[BIT_W][j] == '0) begin
        run_j = run_r + RUN_W'(j + 1);
      end else begin
        run_j = RUN_W'(j + 1) - RUN_W'(lu[BIT_W][j]);
      end
      if (!hit && run_j >= RUN_W'(cnt_r)) begin
        hit   = 1'b1;
        hit_j = BIT_W'(j);
      end
    end
    if (lu[BIT_W][WORD_W-1] == '0) begin
      run_out = run_r + RUN_W'(WORD_W);
    end else begin
      run_out = RUN_W'(WORD_W) - RUN_W'(lu[BIT_W][WORD_W-1]);
    end
    hit_start = (XW'(ev_wa_r) << BIT_W) + XW'(hit_j) + XW'(1) - XW'(cnt_r);
  end

  // Run mask for the word being modified
  always_comb begin
    end_g    = XW'(start_r) + XW'(cnt_r) - XW'(1);
    mod_last = WA_W'(end_g >> BIT_W);
    for (int j = 0; j < WORD_W; j++) begin
      gm      = (XW'(mod_wa_r) << BIT_W) + XW'(j);
      mask[j] = (gm >= XW'(start_r)) && (gm <= end_g);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pool_nxt       = pool_r;
    cnt_nxt        = cnt_r;
    base_nxt       = base_r;
    size_nxt       = size_r;
    panic_nxt      = panic_r;
    start_nxt      = start_r;
    last_wa_nxt    = last_wa_r;
    rd_wa_nxt      = rd_wa_r;
    ev_wa_nxt      = ev_wa_r;
    ev_pend_nxt    = ev_pend_r;
    run_nxt        = run_r;
    mod_wa_nxt     = mod_wa_r;
    check_nxt      = check_r;
    set_nxt        = set_r;
    status_nxt     = status_r;
    first_nxt      = first_r;
    fatal_nxt      = fatal_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_fatal_nxt  = out_fatal_r;
    ram_we         = 1'b0;
    ram_wdata      = wd & ~mask;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt    = in_page_count;
          panic_nxt  = in_panic_on_fail;
          status_nxt = ST_OK;
          first_nxt  = '0;
          fatal_nxt  = 1'b0;
          state_nxt  = S_RESP;
          if (in_opcode == OP_ALLOC) begin
            pool_nxt = in_user_pool;
            base_nxt = in_user_pool ? ubase_r : kbase_r;
            size_nxt = in_user_pool ? usize : ksize;
            set_nxt  = 1'b1;
            if (in_page_count == '0) begin
              status_nxt = ST_ZERO;
            end else if (XW'(in_page_count) > XW'(size_nxt)) begin
              status_nxt = ST_NO_ROOM;
              fatal_nxt  = in_panic_on_fail;
            end else begin
              rd_wa_nxt   = '0;
              ev_pend_nxt = 1'b0;
              run_nxt     = '0;
              last_wa_nxt = WA_W'((XW'(size_nxt) - XW'(1)) >> BIT_W);
              state_nxt   = S_SCAN;
            end
          end else if (in_page_count != '0) begin
            set_nxt  = 1'b0;
            pool_nxt = !in_k;
            base_nxt = fbase;
            size_nxt = fsize;
            if (!in_k && !in_u) begin
              status_nxt = ST_NOT_IN_POOL;
            end else if (XW'(fidx) + XW'(in_page_count) > XW'(fsize)) begin
              status_nxt = ST_BAD_RANGE;
            end else begin
              start_nxt  = PIX_W'(fidx);
              mod_wa_nxt = WA_W'(fidx >> BIT_W);
              check_nxt  = 1'b1;
              state_nxt  = S_MOD_RD;
            end
          end
        end
      end

      S_SCAN: begin
        // keep one read in flight while the previous word is evaluated
        ev_pend_nxt = 1'b1;
        ev_wa_nxt   = rd_wa_r;
        rd_wa_nxt   = rd_wa_r + 1'b1;
        if (ev_pend_r) begin
          if (hit) begin
            start_nxt  = PIX_W'(hit_start);
            mod_wa_nxt = WA_W'(hit_start >> BIT_W);
            first_nxt  = base_r + PAGE_W'(hit_start);
            check_nxt  = 1'b0;
            state_nxt  = S_MOD_RD;
          end else if (ev_wa_r == last_wa_r) begin
            status_nxt = ST_NO_ROOM;
            fatal_nxt  = panic_r;
            state_nxt  = S_RESP;
          end else begin
            run_nxt = run_out;
          end
        end
      end

      S_MOD_RD: begin
        state_nxt = S_MOD_WR;
      end

      S_MOD_WR: begin
        if (check_r) begin
          if ((wd & mask) != mask) begin
            status_nxt = ST_BAD_RANGE;
            state_nxt  = S_RESP;
          end else if (mod_wa_r == mod_last) begin
            // every page in use: go back and clear the run
            check_nxt  = 1'b0;
            mod_wa_nxt = WA_W'(start_r >> BIT_W);
            state_nxt  = S_MOD_RD;
          end else begin
            mod_wa_nxt = mod_wa_r + 1'b1;
            state_nxt  = S_MOD_RD;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = set_r ? (wd | mask) : (wd & ~mask);
          if (mod_wa_r == mod_last) begin
            state_nxt = S_RESP;
          end else begin
            mod_wa_nxt = mod_wa_r + 1'b1;
            state_nxt  = S_MOD_RD;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_first_nxt  = first_r;
          out_fatal_nxt  = fatal_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      ev_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      ev_pend_r   <= ev_pend_nxt;
      rd_vld_r    <= vld_r[ram_raddr];
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pool_r       <= pool_nxt;
    cnt_r        <= cnt_nxt;
    base_r       <= base_nxt;
    size_r       <= size_nxt;
    panic_r      <= panic_nxt;
    start_r      <= start_nxt;
    last_wa_r    <= last_wa_nxt;
    rd_wa_r      <= rd_wa_nxt;
    ev_wa_r      <= ev_wa_nxt;
    run_r        <= run_nxt;
    mod_wa_r     <= mod_wa_nxt;
    check_r      <= check_nxt;
    set_r        <= set_nxt;
    status_r     <= status_nxt;
    first_r      <= first_nxt;
    fatal_r      <= fatal_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_fatal_r  <= out_fatal_nxt;
  end

endmodule
